@@ design/spd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// shared types and constants of the shortest path block: field widths,
// opcodes and the command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package spd_pkg;

   // beat field widths
   localparam int VID_W    = 4;
   localparam int WIN_W    = 16;
   localparam int PATH_W   = 20;
   localparam int REQ_DW   = 32;
   localparam int RSP_DW   = 32;
   localparam int RSP_PAD  = RSP_DW - (VID_W + PATH_W + 1);

   localparam logic [PATH_W-1:0] PATH_MAX = '1;

   // opcode carried in req_tuser
   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_RUN   = 1'b1;

   typedef struct packed {
      logic wr_weight;
      logic take_src;
      logic clr_step;
      logic init;
      logic idx_clr;
      logic scan_rd;
      logic pick;
      logic relax_rd;
      logic out_ld;
      logic out_next;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic src_ok;
      logic idx_last;
      logic found;
      logic step_last;
      logic rsp_taken;
   } sts_type;

endpackage

@@ design/spd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ctrl
// sequencer: clearing pass, weight loads, scan/relax rounds and result
// readout, driving the datapath through command strobes
// ----------------------------------------------------------------------------
module spd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_ready,
   input  spd_pkg::sts_type sts,
   output spd_pkg::cmd_type cmd
);
   import spd_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_END, ST_DECIDE,
      ST_RELAX, ST_RELAX_END, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid & ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OPC_RUN) begin
                  cmd.take_src = 1'b1;
                  state_in     = ST_INIT;
               end else begin
                  cmd.wr_weight = 1'b1;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = sts.src_ok ? ST_SCAN : ST_OUT_RD;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.idx_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: state_in = ST_DECIDE;
         ST_DECIDE: begin
            cmd.idx_clr = 1'b1;
            if (sts.found) begin
               cmd.pick = 1'b1;
               state_in = ST_RELAX;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         ST_RELAX: begin
            cmd.relax_rd = 1'b1;
            if (sts.idx_last) state_in = ST_RELAX_END;
         end
         ST_RELAX_END: begin
            cmd.idx_clr = 1'b1;
            state_in    = sts.step_last ? ST_OUT_RD : ST_SCAN;
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            cmd.out_ld = 1'b1;
            state_in   = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (sts.rsp_taken) begin
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

@@ design/spd_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_dpath
// weight and distance memories, visited/finite flags, min scan, relaxation
// and the result register
// ----------------------------------------------------------------------------
module spd_dpath #(
   parameter int NUM_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spd_pkg::cmd_type             cmd,
   output spd_pkg::sts_type             sts,
   input  logic [spd_pkg::VID_W-1:0]    row_vertex,
   input  logic [spd_pkg::VID_W-1:0]    col_vertex,
   input  logic [spd_pkg::WIN_W-1:0]    edge_weight,
   input  logic [spd_pkg::VID_W-1:0]    source_vertex,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [spd_pkg::VID_W-1:0]    vertex_id,
   output logic [spd_pkg::PATH_W-1:0]   path_length,
   output logic                         reachable,
   output logic                         last_of_run
);
   import spd_pkg::*;

   localparam int IDX_W  = $clog2(NUM_VERTICES);
   localparam int CELLS  = NUM_VERTICES * NUM_VERTICES;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int DIST_W = WEIGHT_BITS + IDX_W;

   logic [WEIGHT_BITS-1:0] weight_mem_ff [CELLS];
   logic [DIST_W-1:0]      dist_mem_ff [NUM_VERTICES];

   logic [ADDR_W-1:0]      clr_addr_ff;
   logic [IDX_W-1:0]       idx_ff, step_ff, pick_ff, v_d1_ff;
   logic [VID_W-1:0]       src_ff;
   logic [NUM_VERTICES-1:0] known_ff, done_ff;
   logic                   found_ff, scan_d1_ff, relax_d1_ff, rsp_valid_ff;
   logic [DIST_W-1:0]      least_ff, d_rd_ff;
   logic [WEIGHT_BITS-1:0] w_rd_ff;
   logic [VID_W-1:0]       vid_ff;
   logic [PATH_W-1:0]      path_ff;
   logic                   reach_ff, last_ff;

   logic                   row_ok, col_ok, src_ok, idx_last;
   logic [IDX_W-1:0]       src_idx;
   logic [31:0]            wt_ext;
   logic [ADDR_W-1:0]      wr_addr, w_waddr, w_raddr;
   logic                   w_we;
   logic [WEIGHT_BITS-1:0] w_wdata;
   logic [DIST_W-1:0]      cand, d_wdata;
   logic [IDX_W-1:0]       d_waddr;
   logic                   d_we, relax_upd, scan_hit;
   logic [63:0]            d_ext;
   logic [PATH_W-1:0]      d_sat;

   assign row_ok   = 32'(row_vertex) < NUM_VERTICES;
   assign col_ok   = 32'(col_vertex) < NUM_VERTICES;
   assign src_ok   = 32'(src_ff) < NUM_VERTICES;
   assign src_idx  = IDX_W'(src_ff);
   assign idx_last = idx_ff == IDX_W'(NUM_VERTICES - 1);
   assign wt_ext   = 32'(edge_weight);

   assign wr_addr = ADDR_W'(row_vertex) * ADDR_W'(NUM_VERTICES) + ADDR_W'(col_vertex);
   assign w_raddr = ADDR_W'(pick_ff) * ADDR_W'(NUM_VERTICES) + ADDR_W'(idx_ff);
   assign w_we    = cmd.clr_step | (cmd.wr_weight & row_ok & col_ok);
   assign w_waddr = cmd.clr_step ? clr_addr_ff : wr_addr;
   assign w_wdata = cmd.clr_step ? '0 : wt_ext[WEIGHT_BITS-1:0];

   // weight matrix, one registered read port
   always_ff @(posedge clock) begin
      if (w_we) weight_mem_ff[w_waddr] <= w_wdata;
      w_rd_ff <= weight_mem_ff[w_raddr];
   end

   // relaxation of the vertex read last cycle
   assign cand      = least_ff + DIST_W'(w_rd_ff);
   assign relax_upd = relax_d1_ff & ~done_ff[v_d1_ff] & (w_rd_ff != '0) &
                      (~known_ff[v_d1_ff] | (cand < d_rd_ff));
   assign scan_hit  = scan_d1_ff & ~done_ff[v_d1_ff] & known_ff[v_d1_ff] &
                      (~found_ff | (d_rd_ff < least_ff));

   assign d_we    = (cmd.init & src_ok) | relax_upd;
   assign d_waddr = cmd.init ? src_idx : v_d1_ff;
   assign d_wdata = cmd.init ? '0 : cand;

   // distance store, read address always the running index
   always_ff @(posedge clock) begin
      if (d_we) dist_mem_ff[d_waddr] <= d_wdata;
      d_rd_ff <= dist_mem_ff[idx_ff];
   end

   assign d_ext = 64'(d_rd_ff);
   assign d_sat = (d_ext > 64'(PATH_MAX)) ? PATH_MAX : d_ext[PATH_W-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         known_ff     <= '0;
         done_ff      <= '0;
         found_ff     <= 1'b0;
         scan_d1_ff   <= 1'b0;
         relax_d1_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_d1_ff  <= cmd.scan_rd;
         relax_d1_ff <= cmd.relax_rd;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.init | cmd.idx_clr) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_rd | cmd.relax_rd | cmd.out_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (scan_hit) found_ff <= 1'b1;
         if (cmd.init) begin
            known_ff <= src_ok ? (NUM_VERTICES'(1) << src_idx) : '0;
            done_ff  <= '0;
            step_ff  <= '0;
         end
         if (relax_upd) known_ff[v_d1_ff] <= 1'b1;
         if (cmd.pick) begin
            done_ff[pick_ff] <= 1'b1;
            step_ff          <= step_ff + 1'b1;
         end
         if (cmd.out_ld) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff & rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_d1_ff <= idx_ff;
      if (cmd.take_src) src_ff <= source_vertex;
      if (scan_hit) begin
         least_ff <= d_rd_ff;
         pick_ff  <= v_d1_ff;
      end
      if (cmd.out_ld) begin
         vid_ff   <= VID_W'(idx_ff);
         reach_ff <= known_ff[idx_ff];
         path_ff  <= known_ff[idx_ff] ? d_sat : '0;
         last_ff  <= idx_last;
      end
   end

   assign sts.clr_last  = clr_addr_ff == ADDR_W'(CELLS - 1);
   assign sts.src_ok    = src_ok;
   assign sts.idx_last  = idx_last;
   assign sts.found     = found_ff;
   assign sts.step_last = step_ff == IDX_W'(NUM_VERTICES - 1);
   assign sts.rsp_taken = rsp_valid_ff & rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign vertex_id   = vid_ff;
   assign path_length = path_ff;
   assign reachable   = reach_ff;
   assign last_of_run = last_ff;

endmodule

@@ design/shortest_path_dense_graph.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_dense_graph
// single-source shortest paths over a dense weighted adjacency matrix
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_*   | in  | tuser: opcode; tdata: row, col, weight, source
//  rsp_*   | out | tdata: vertex id, path length, reachable; tlast: last vertex
//
//  weight load beat: written as it is accepted, back to back while idle
//  run beat: an init step, then per selected vertex (at most N-1) a scan
//    and a relax pass, each over all N vertices in turn through the single
//    read port of each memory; one more scan when the search ends early;
//    then per result beat a read, a load and a wait for rsp_tready
//  after reset a clearing pass over all N*N cells zeroes the weight matrix,
//    req_tready stays low meanwhile
//  req_tready is low from a run beat until its last result beat is taken
// ----------------------------------------------------------------------------
module shortest_path_dense_graph #(
   parameter int NUM_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [3:0] row_vertex, [7:4] col_vertex, [23:8] edge_weight,
   // [27:24] source_vertex, [31:28] zero
   input  logic [spd_pkg::REQ_DW-1:0]   req_tdata,
   // [0] opcode
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [3:0] vertex_id, [23:4] path_length, [24] reachable, [31:25] zero
   output logic [spd_pkg::RSP_DW-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);
   import spd_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [VID_W-1:0]    vertex_id;
   logic [PATH_W-1:0]   path_length;
   logic                reachable;

   // sequencer
   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memories, flags, scan and relaxation
   spd_dpath #(
      .NUM_VERTICES (NUM_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .row_vertex    (req_tdata[3:0]),
      .col_vertex    (req_tdata[7:4]),
      .edge_weight   (req_tdata[23:8]),
      .source_vertex (req_tdata[27:24]),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .vertex_id     (vertex_id),
      .path_length   (path_length),
      .reachable     (reachable),
      .last_of_run   (rsp_tlast)
   );

   // pack the result beat, low field first
   assign rsp_tdata = {{RSP_PAD{1'b0}}, reachable, path_length, vertex_id};

   // one item at a time: never ready while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req ready while result pending");

   // the block goes back to idle right after the last beat of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after last result");

   // a fresh result needs a memory read first, so no beat follows directly
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid)
      else $error("result beat issued without read");

   // unreachable vertices report zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !reachable |-> path_length == '0)
      else $error("nonzero length on unreachable vertex");

endmodule
